>>> src/i2c_clock_divider_search_core_defines.svh
// Assertion macros for the divider search core.
`ifndef I2C_CLOCK_DIVIDER_SEARCH_CORE_DEFINES_SVH
`define I2C_CLOCK_DIVIDER_SEARCH_CORE_DEFINES_SVH

// Check a condition in the same cycle as its trigger.
`define I2CCDS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Check a condition in the cycle after its trigger.
`define I2CCDS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

>>> src/i2ccds_pkg.sv
// Shared types, constants and divider table for the divider search core.
package i2ccds_pkg;

    localparam int unsigned C_TABLE_SIZE = 64;
    localparam int unsigned C_IDX_W      = $clog2(C_TABLE_SIZE);

    localparam logic [31:0] C_CLK_RESET  = 32'd48000000;
    localparam logic [31:0] C_KILO       = 32'd1000;
    localparam logic [18:0] C_HOLD_SCALE = 19'd500000;
    // ceil(2^38 / 1000): x / 1000 == (x * C_KILO_RECIP) >> 38 for any 32-bit x.
    localparam logic [28:0] C_KILO_RECIP = 29'h10624DD3;

    // Multiplier codes: x1, x2, x4.
    localparam logic [1:0] C_MULT_X1 = 2'd0;
    localparam logic [1:0] C_MULT_X2 = 2'd1;
    localparam logic [1:0] C_MULT_X4 = 2'd2;

    localparam logic [11:0] C_DIV_TABLE [0:C_TABLE_SIZE-1] = '{
        12'd20,   12'd22,   12'd24,   12'd26,   12'd28,   12'd30,   12'd34,   12'd40,
        12'd28,   12'd32,   12'd36,   12'd40,   12'd44,   12'd48,   12'd56,   12'd68,
        12'd48,   12'd56,   12'd64,   12'd72,   12'd80,   12'd88,   12'd104,  12'd128,
        12'd80,   12'd96,   12'd112,  12'd128,  12'd144,  12'd160,  12'd192,  12'd240,
        12'd160,  12'd192,  12'd224,  12'd256,  12'd288,  12'd320,  12'd384,  12'd480,
        12'd320,  12'd384,  12'd448,  12'd512,  12'd576,  12'd640,  12'd768,  12'd960,
        12'd640,  12'd768,  12'd896,  12'd1024, 12'd1152, 12'd1280, 12'd1536, 12'd1920,
        12'd1280, 12'd1536, 12'd1792, 12'd2048, 12'd2304, 12'd2560, 12'd3072, 12'd3840
    };

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;      // capture input word, clear best
        logic save_den;  // keep clock / 1000 quotient
        logic prep_c;    // set up current candidate
        logic start;     // launch divider
        logic eval;      // score candidate and advance
        logic emit;      // load result register
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic div_done;
        logic hit;       // current candidate error is zero
        logic last;      // current candidate is the final one
    } t_sts;

endpackage

>>> src/i2ccds_div.sv
// Restoring 32-bit unsigned divider, one quotient bit per cycle.
module i2ccds_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [31:0] i_dividend,
    input  logic [31:0] i_divisor,
    output logic        o_done,
    output logic [31:0] o_quotient
);
    logic        r_busy, n_busy;
    logic        r_done, n_done;
    logic [4:0]  r_cnt, n_cnt;
    logic [31:0] r_rem, n_rem;
    logic [31:0] r_quo, n_quo;
    logic [31:0] r_dsr, n_dsr;
    logic [32:0] w_shift;
    logic [32:0] w_diff;
    logic        w_ge;

    assign w_shift = {r_rem, r_quo[31]};
    assign w_diff  = w_shift - {1'b0, r_dsr};
    // A zero divisor always passes, giving an all-ones quotient.
    assign w_ge    = (w_shift >= {1'b0, r_dsr});

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_quo  = r_quo;
        n_dsr  = r_dsr;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = '1;
            n_rem  = '0;
            n_quo  = i_dividend;
            n_dsr  = i_divisor;
        end else if (r_busy) begin
            n_rem = w_ge ? w_diff[31:0] : w_shift[31:0];
            n_quo = {r_quo[30:0], w_ge};
            n_cnt = r_cnt - 5'd1;
            if (r_cnt == 5'd0) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_cnt <= n_cnt;
        r_rem <= n_rem;
        r_quo <= n_quo;
        r_dsr <= n_dsr;
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;
endmodule

>>> src/i2ccds_dp.sv
// Datapath: clock register, candidate operands, divider, best-match tracking.
module i2ccds_dp (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_wr_en,
    input  logic [31:0]        i_cfg_wr_data,
    input  logic               i_mode,
    input  logic [31:0]        i_target,
    input  i2ccds_pkg::t_cmd   i_cmd,
    output i2ccds_pkg::t_sts   o_sts,
    output logic [1:0]         o_mult_select,
    output logic [5:0]         o_divider_index
);
    import i2ccds_pkg::*;

    logic [31:0]        r_clk_hz;
    logic               r_mode;
    logic [31:0]        r_target;
    logic [31:0]        r_den;
    logic [1:0]         r_m;
    logic [C_IDX_W-1:0] r_i;
    logic [31:0]        r_best_err;
    logic [1:0]         r_best_m;
    logic [C_IDX_W-1:0] r_best_i;
    logic [31:0]        r_dividend;
    logic [31:0]        r_divisor;
    logic [1:0]         r_out_m;
    logic [C_IDX_W-1:0] r_out_i;

    logic [13:0] w_d;
    logic [32:0] w_prod;
    logic [60:0] w_kilo_prod;
    logic        w_div_done;
    logic [31:0] w_quo;
    logic [31:0] w_err;

    assign w_d    = 14'(C_DIV_TABLE[r_i]) << r_m;
    assign w_prod = 33'(w_d) * 33'(C_HOLD_SCALE);
    // Clock / 1000 by reciprocal multiply; the quotient sits in bits 60:38.
    assign w_kilo_prod = 61'(r_clk_hz) * 61'(C_KILO_RECIP);
    assign w_err  = (r_target > w_quo) ? (r_target - w_quo) : (w_quo - r_target);

    i2ccds_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.start),
        .i_dividend (r_dividend),
        .i_divisor  (r_divisor),
        .o_done     (w_div_done),
        .o_quotient (w_quo)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clk_hz <= C_CLK_RESET;
        end else if (i_cfg_wr_en) begin
            r_clk_hz <= i_cfg_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mode     <= i_mode;
            r_target   <= i_target;
            r_m        <= C_MULT_X1;
            r_i        <= '0;
            r_best_err <= '1;
            r_best_m   <= C_MULT_X1;
            r_best_i   <= '0;
        end
        if (i_cmd.save_den) begin
            r_den <= 32'(w_kilo_prod[60:38]);
        end
        if (i_cmd.prep_c) begin
            // Hold-time product wraps to 32 bits.
            r_dividend <= r_mode ? w_prod[31:0] : r_clk_hz;
            r_divisor  <= r_mode ? r_den : 32'(w_d);
        end
        if (i_cmd.eval) begin
            if (w_err < r_best_err) begin
                r_best_err <= w_err;
                r_best_m   <= r_m;
                r_best_i   <= r_i;
            end
            r_i <= r_i + 1'b1;
            if (r_i == '1) begin
                r_m <= r_m + 2'd1;
            end
        end
        if (i_cmd.emit) begin
            r_out_m <= r_best_m;
            r_out_i <= r_best_i;
        end
    end

    assign o_sts.div_done = w_div_done;
    assign o_sts.hit      = (w_err == 32'd0);
    assign o_sts.last     = (r_m == C_MULT_X4) && (r_i == '1);

    assign o_mult_select   = r_out_m;
    assign o_divider_index = r_out_i;
endmodule

>>> src/i2ccds_ctrl.sv
// Controller: sequences the divisor set-up and the candidate scan.
module i2ccds_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    input  i2ccds_pkg::t_sts i_sts,
    output i2ccds_pkg::t_cmd o_cmd
);
    import i2ccds_pkg::*;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_KPREP  = 4'd1;
    localparam logic [3:0] S_CPREP  = 4'd4;
    localparam logic [3:0] S_CSTART = 4'd5;
    localparam logic [3:0] S_CWAIT  = 4'd6;
    localparam logic [3:0] S_EVAL   = 4'd7;
    localparam logic [3:0] S_FIN    = 4'd8;

    logic [3:0] r_state, n_state;
    logic       r_ovalid, n_ovalid;

    always_comb begin
        n_state  = r_state;
        n_ovalid = r_ovalid;
        o_cmd    = '0;
        if (r_ovalid && i_out_ready) begin
            n_ovalid = 1'b0;
        end
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_KPREP;
                end
            end
            S_KPREP: begin
                o_cmd.save_den = 1'b1;
                n_state        = S_CPREP;
            end
            S_CPREP: begin
                o_cmd.prep_c = 1'b1;
                n_state      = S_CSTART;
            end
            S_CSTART: begin
                o_cmd.start = 1'b1;
                n_state     = S_CWAIT;
            end
            S_CWAIT: begin
                if (i_sts.div_done) begin
                    n_state = S_EVAL;
                end
            end
            S_EVAL: begin
                o_cmd.eval = 1'b1;
                // Stop on an exact match or after the last candidate.
                n_state = (i_sts.hit || i_sts.last) ? S_FIN : S_CPREP;
            end
            S_FIN: begin
                // Hold until the result register is free.
                if (!r_ovalid || i_out_ready) begin
                    o_cmd.emit = 1'b1;
                    n_ovalid   = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_ovalid;
endmodule

>>> src/i2c_clock_divider_search_core.sv
// Each word gets a set-up step, then each candidate is prepared, run through the serial
// divider and scored; the best is then loaded as the result. At most 192 are scanned.
// Throughput: one word at a time; the next word is taken the cycle after the result loads.
// A waiting result does not block input, but the next result holds until it is taken.
// Synchronous active-low reset clears control state and loads the 48 MHz clock.
module i2c_clock_divider_search_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [31:0] i_cfg_wr_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [31:0] target
    input  logic        s_axis_tuser,   // [0] mode
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata    // [1:0] mult_select, [7:2] divider_index
);
    import i2ccds_pkg::*;
    `include "i2c_clock_divider_search_core_defines.svh"

    t_cmd       w_cmd;
    t_sts       w_sts;
    logic [1:0] w_mult_select;
    logic [5:0] w_divider_index;

    i2ccds_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    i2ccds_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_wr_data   (i_cfg_wr_data),
        .i_mode          (s_axis_tuser),
        .i_target        (s_axis_tdata),
        .i_cmd           (w_cmd),
        .o_sts           (w_sts),
        .o_mult_select   (w_mult_select),
        .o_divider_index (w_divider_index)
    );

    assign m_axis_tdata = {w_divider_index, w_mult_select};

    `I2CCDS_ASSERT_NOW(a_mult_range, m_axis_tvalid, m_axis_tdata[1:0] != 2'd3, "bad mult code")
    `I2CCDS_ASSERT_NEXT(a_one_at_a_time, s_axis_tvalid && s_axis_tready, !s_axis_tready, "ready after accept")
    `I2CCDS_ASSERT_NOW(a_div_busy, w_sts.div_done, !s_axis_tready && !w_cmd.start, "divider done while idle")
endmodule
